### sv/bmp_stream_decoder_top_assert.svh
// Assertion macros for the bitmap stream decoder checker.
// Included by the checker file only; expects clk and rst_n in scope.
`ifndef BMP_STREAM_DECODER_TOP_ASSERT_SVH
`define BMP_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bsd_pkg.sv
// Shared types and codes for the bitmap stream decoder.
// No dependencies; used by every module of the decoder.
`default_nettype none

package bsd_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Status codes.
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_BAD_SIG    = 4'd1;
    localparam logic [3:0] ST_SHORT_HDR  = 4'd2;
    localparam logic [3:0] ST_BAD_DIMS   = 4'd3;
    localparam logic [3:0] ST_COMPRESSED = 4'd4;
    localparam logic [3:0] ST_BAD_DEPTH  = 4'd5;
    localparam logic [3:0] ST_TOO_LARGE  = 4'd6;
    localparam logic [3:0] ST_BAD_OFFSET = 4'd7;
    localparam logic [3:0] ST_TRUNCATED  = 4'd8;

    // Header layout and format constants.
    localparam logic [7:0]  SIG_BYTE0       = 8'h42;
    localparam logic [7:0]  SIG_BYTE1       = 8'h4D;
    localparam logic [5:0]  HDR_LAST_POS    = 6'd53;
    localparam logic [31:0] MIN_DATA_OFFSET = 32'd54;
    localparam logic [15:0] DEPTH_24        = 16'd24;
    localparam logic [15:0] DEPTH_32        = 16'd32;
    localparam logic [7:0]  OPAQUE_ALPHA    = 8'd255;

    // Queue between parser and emitter.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  status;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last_pixel;
        logic        last_in_run;
    } bsd_result_t;

    // One queue entry: a main result plus an optional trailing error.
    typedef struct packed {
        bsd_result_t main;
        logic        trail;
        logic [3:0]  trail_status;
    } bsd_entry_t;

endpackage

`default_nettype wire

### sv/bsd_front.sv
// Parser front end of the bitmap stream decoder: header capture, validation,
// pixel assembly and coordinate tracking. Depends on bsd_pkg.
`default_nettype none

module bsd_front #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          data_byte,
    input  wire logic                start_of_file,
    input  wire logic                end_of_file,
    output logic                     push,
    output bsd_pkg::bsd_entry_t      push_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam logic [31:0] MAX_DIM_L = 32'(MAX_DIM);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_PAD
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [31:0]        pos_reg, pos_next;
    logic [31:0]        offset_reg, offset_next;
    logic [31:0]        wraw_reg, wraw_next;
    logic [31:0]        hraw_reg, hraw_next;
    logic [15:0]        depth_reg, depth_next;
    logic [31:0]        comp_reg, comp_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic               bottom_up_reg, bottom_up_next;
    logic               is32_reg, is32_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [1:0]         bip_reg, bip_next;
    logic [1:0]         pad_reg, pad_next;
    logic [23:0]        pix_reg, pix_next;
    logic               push_reg, push_next;
    bsd_pkg::bsd_entry_t ent_reg, ent_next;

    // Parse one byte and build the queue entry it causes.
    always_comb
    begin
        phase_t            ph;
        logic [31:0]       eff_pos;
        logic [5:0]        p;
        logic [31:0]       hmag;
        logic              main_valid;
        logic [23:0]       pix_cur;
        logic              pix_done;
        logic [DIM_W-1:0]  col_inc;
        logic [DIM_W-1:0]  row_inc;
        logic [DIM_W-1:0]  ypos;
        logic [31:0]       x32;
        logic [31:0]       y32;
        logic [1:0]        pad_dec;

        phase_next     = phase_reg;
        pos_next       = pos_reg;
        offset_next    = offset_reg;
        wraw_next      = wraw_reg;
        hraw_next      = hraw_reg;
        depth_next     = depth_reg;
        comp_next      = comp_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        bottom_up_next = bottom_up_reg;
        is32_next      = is32_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        bip_next       = bip_reg;
        pad_next       = pad_reg;
        pix_next       = pix_reg;
        push_next      = 1'b0;
        ent_next       = ent_reg;

        ph         = start_of_file ? PH_HEADER : phase_reg;
        eff_pos    = start_of_file ? 32'd0 : pos_reg;
        p          = eff_pos[5:0];
        hmag       = hraw_reg[31] ? (32'd0 - hraw_reg) : hraw_reg;
        main_valid = 1'b0;
        pix_cur    = pix_reg;
        pix_done   = 1'b0;
        col_inc    = col_reg + 1'b1;
        row_inc    = row_reg + 1'b1;
        ypos       = bottom_up_reg ? (height_reg - 1'b1 - row_reg) : row_reg;
        x32        = 32'(col_reg);
        y32        = 32'(ypos);
        pad_dec    = pad_reg - 1'b1;

        if (accept && ph != PH_IDLE)
        begin
            ent_next   = '0;
            phase_next = ph;

            if (ph == PH_HEADER)
            begin
                // Header bytes: signature check, then little-endian field capture.
                if ((p == 6'd0 && data_byte != bsd_pkg::SIG_BYTE0) ||
                    (p == 6'd1 && data_byte != bsd_pkg::SIG_BYTE1))
                begin
                    main_valid           = 1'b1;
                    ent_next.main.kind   = bsd_pkg::KIND_ERROR;
                    ent_next.main.status = bsd_pkg::ST_BAD_SIG;
                    phase_next           = PH_IDLE;
                end
                else
                begin
                    case (p)
                        6'd10: offset_next[7:0]   = data_byte;
                        6'd11: offset_next[15:8]  = data_byte;
                        6'd12: offset_next[23:16] = data_byte;
                        6'd13: offset_next[31:24] = data_byte;
                        6'd18: wraw_next[7:0]     = data_byte;
                        6'd19: wraw_next[15:8]    = data_byte;
                        6'd20: wraw_next[23:16]   = data_byte;
                        6'd21: wraw_next[31:24]   = data_byte;
                        6'd22: hraw_next[7:0]     = data_byte;
                        6'd23: hraw_next[15:8]    = data_byte;
                        6'd24: hraw_next[23:16]   = data_byte;
                        6'd25: hraw_next[31:24]   = data_byte;
                        6'd28: depth_next[7:0]    = data_byte;
                        6'd29: depth_next[15:8]   = data_byte;
                        6'd30: comp_next[7:0]     = data_byte;
                        6'd31: comp_next[15:8]    = data_byte;
                        6'd32: comp_next[23:16]   = data_byte;
                        6'd33: comp_next[31:24]   = data_byte;
                        default: ;
                    endcase

                    // Validation at the final header byte, in priority order.
                    if (p == bsd_pkg::HDR_LAST_POS)
                    begin
                        main_valid         = 1'b1;
                        ent_next.main.kind = bsd_pkg::KIND_ERROR;
                        phase_next         = PH_IDLE;
                        if (wraw_reg[31] || wraw_reg == 32'd0 || hraw_reg == 32'd0)
                            ent_next.main.status = bsd_pkg::ST_BAD_DIMS;
                        else if (comp_reg != 32'd0)
                            ent_next.main.status = bsd_pkg::ST_COMPRESSED;
                        else if (depth_reg != bsd_pkg::DEPTH_24 &&
                                 depth_reg != bsd_pkg::DEPTH_32)
                            ent_next.main.status = bsd_pkg::ST_BAD_DEPTH;
                        else if (wraw_reg > MAX_DIM_L || hmag > MAX_DIM_L)
                            ent_next.main.status = bsd_pkg::ST_TOO_LARGE;
                        else if (offset_reg < bsd_pkg::MIN_DATA_OFFSET)
                            ent_next.main.status = bsd_pkg::ST_BAD_OFFSET;
                        else
                        begin
                            ent_next.main.kind         = bsd_pkg::KIND_HEADER;
                            ent_next.main.status       = bsd_pkg::ST_OK;
                            ent_next.main.image_width  = wraw_reg[12:0];
                            ent_next.main.image_height = hmag[12:0];
                            width_next     = wraw_reg[DIM_W-1:0];
                            height_next    = hmag[DIM_W-1:0];
                            bottom_up_next = ~hraw_reg[31];
                            is32_next      = (depth_reg == bsd_pkg::DEPTH_32);
                            col_next       = '0;
                            row_next       = '0;
                            bip_next       = 2'd0;
                            phase_next     = PH_SKIP;
                        end
                    end
                end
            end
            else
            begin
                // Skip to the data offset; the byte at the offset is pixel data.
                if (ph == PH_SKIP && eff_pos >= offset_reg)
                begin
                    ph         = PH_PIXELS;
                    phase_next = PH_PIXELS;
                end

                if (ph == PH_PIXELS)
                begin
                    case (bip_reg)
                        2'd0: pix_cur[7:0]   = data_byte;
                        2'd1: pix_cur[15:8]  = data_byte;
                        2'd2: pix_cur[23:16] = data_byte;
                        default: ;
                    endcase
                    pix_done = is32_reg ? (bip_reg == 2'd3) : (bip_reg == 2'd2);

                    if (!pix_done)
                    begin
                        pix_next = pix_cur;
                        bip_next = bip_reg + 1'b1;
                    end
                    else
                    begin
                        // Complete pixel: BGR(A) to RGBA with its destination.
                        main_valid               = 1'b1;
                        ent_next.main.kind       = bsd_pkg::KIND_PIXEL;
                        ent_next.main.status     = bsd_pkg::ST_OK;
                        ent_next.main.pixel_x    = x32[11:0];
                        ent_next.main.pixel_y    = y32[11:0];
                        ent_next.main.red        = pix_cur[23:16];
                        ent_next.main.green      = pix_cur[15:8];
                        ent_next.main.blue       = pix_cur[7:0];
                        ent_next.main.alpha      = is32_reg ? data_byte
                                                            : bsd_pkg::OPAQUE_ALPHA;
                        ent_next.main.last_pixel = (col_inc == width_reg) &&
                                                   (row_inc == height_reg);
                        bip_next                 = 2'd0;
                        if (ent_next.main.last_pixel)
                            phase_next = PH_IDLE;
                        else if (col_inc == width_reg)
                        begin
                            col_next = '0;
                            row_next = row_inc;
                            pad_next = is32_reg ? 2'd0 : width_reg[1:0];
                            if (!is32_reg && width_reg[1:0] != 2'd0)
                                phase_next = PH_PAD;
                        end
                        else
                            col_next = col_inc;
                    end
                end
                else if (ph == PH_PAD)
                begin
                    // Drop row padding.
                    pad_next = pad_dec;
                    if (pad_dec == 2'd0)
                        phase_next = PH_PIXELS;
                end
            end

            if (eff_pos != 32'hFFFF_FFFF)
                pos_next = eff_pos + 32'd1;
            else
                pos_next = eff_pos;

            // End of file while the image is still open.
            if (end_of_file && phase_next != PH_IDLE)
            begin
                if (main_valid)
                begin
                    ent_next.trail        = 1'b1;
                    ent_next.trail_status = (phase_next == PH_HEADER) ?
                                            bsd_pkg::ST_SHORT_HDR : bsd_pkg::ST_TRUNCATED;
                end
                else
                begin
                    main_valid           = 1'b1;
                    ent_next.main.kind   = bsd_pkg::KIND_ERROR;
                    ent_next.main.status = (phase_next == PH_HEADER) ?
                                           bsd_pkg::ST_SHORT_HDR : bsd_pkg::ST_TRUNCATED;
                end
                phase_next = PH_IDLE;
            end

            push_next = main_valid;
        end
    end

    // Parser state and the registered queue write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            offset_reg    <= '0;
            wraw_reg      <= '0;
            hraw_reg      <= '0;
            depth_reg     <= '0;
            comp_reg      <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            bottom_up_reg <= 1'b0;
            is32_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            bip_reg       <= '0;
            pad_reg       <= '0;
            pix_reg       <= '0;
            push_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            offset_reg    <= offset_next;
            wraw_reg      <= wraw_next;
            hraw_reg      <= hraw_next;
            depth_reg     <= depth_next;
            comp_reg      <= comp_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            bottom_up_reg <= bottom_up_next;
            is32_reg      <= is32_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            bip_reg       <= bip_next;
            pad_reg       <= pad_next;
            pix_reg       <= pix_next;
            push_reg      <= push_next;
        end
    end

    // Entry payload needs no reset.
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign push      = push_reg;
    assign push_data = ent_reg;

endmodule

`default_nettype wire

### sv/bsd_queue.sv
// Short first-in first-out queue of parsed entries between parser and emitter.
// Depends on bsd_pkg for the entry type and depth.
`default_nettype none

module bsd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  bsd_pkg::bsd_entry_t      push_data,
    input  wire logic                pop,
    output bsd_pkg::bsd_entry_t      pop_data,
    output logic                     empty,
    output logic                     full,
    output logic                     almost_full
);

    localparam int PW = bsd_pkg::QUEUE_PTR_W;

    bsd_pkg::bsd_entry_t slots_reg [bsd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PW:0]         count_reg, count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW + 1)'(push) - (PW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data    = slots_reg[rd_ptr_reg];
    assign empty       = (count_reg == '0);
    assign full        = (count_reg == (PW + 1)'(bsd_pkg::QUEUE_DEPTH));
    assign almost_full = (count_reg >= (PW + 1)'(bsd_pkg::QUEUE_DEPTH - 1));

endmodule

`default_nettype wire

### sv/bsd_back.sv
// Result emitter of the bitmap stream decoder: drains the queue and expands
// each entry into one or two results in an output register. Depends on bsd_pkg.
`default_nettype none

module bsd_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  bsd_pkg::bsd_entry_t      entry,
    input  wire logic                empty,
    output logic                     pop,
    input  wire logic                result_stall,
    output logic                     result_valid,
    output bsd_pkg::bsd_result_t     result
);

    logic                  out_valid_reg, out_valid_next;
    bsd_pkg::bsd_result_t  out_reg, out_next;
    logic                  pend_reg, pend_next;
    logic [3:0]            pend_status_reg, pend_status_next;

    // Load the output register whenever it is empty or being transferred.
    always_comb
    begin
        logic load;

        load             = !out_valid_reg || !result_stall;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        pend_next        = pend_reg;
        pend_status_next = pend_status_reg;
        pop              = 1'b0;

        if (load)
        begin
            if (pend_reg)
            begin
                // Trailing error after the main result of the same byte.
                out_valid_next       = 1'b1;
                out_next             = '0;
                out_next.kind        = bsd_pkg::KIND_ERROR;
                out_next.status      = pend_status_reg;
                out_next.last_in_run = 1'b1;
                pend_next            = 1'b0;
            end
            else if (!empty)
            begin
                pop                  = 1'b1;
                out_valid_next       = 1'b1;
                out_next             = entry.main;
                out_next.last_in_run = !entry.trail;
                pend_next            = entry.trail;
                pend_status_next     = entry.trail_status;
            end
            else
                out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_reg         <= out_next;
        pend_status_reg <= pend_status_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

### sv/bmp_stream_decoder_top.sv
// Bitmap stream decoder: byte stream in, header, pixel and error results out.
// Instantiates bsd_front, bsd_queue and bsd_back; depends on bsd_pkg.
//
// Usage:
//   Input channel: one file byte per transfer (byte_valid / byte_stall), with
//   start_of_file on byte 0 of a file and end_of_file on its last byte.
//   Output channel: one result per transfer (result_valid / result_stall):
//   a header result once 54 header bytes pass the checks, then one pixel
//   per 3 or 4 data bytes with RGBA and destination x, y, or an error.
//   Throughput: one byte per cycle while byte_stall is low. A byte that
//   closes a file early can give two results, a main result and then a
//   trailing error. A result passes the parser register and a queue slot
//   before it is loaded into the output register.
//   A four-entry queue separates parser and emitter; byte_stall rises only
//   when that queue is nearly full because the receiver holds result_stall.
//   Reset clears the parser to idle and empties the queue and the output;
//   bytes before the next start_of_file are ignored.
`default_nettype none

module bmp_stream_decoder_top #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_stall,
    input  wire logic [7:0]   data_byte,
    input  wire logic         start_of_file,
    input  wire logic         end_of_file,
    output logic              result_valid,
    input  wire logic         result_stall,
    output logic [1:0]        kind,
    output logic [3:0]        status,
    output logic [11:0]       pixel_x,
    output logic [11:0]       pixel_y,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic [7:0]        alpha,
    output logic [12:0]       image_width,
    output logic [12:0]       image_height,
    output logic              last_pixel,
    output logic              last_in_run
);

    logic                  accept;
    logic                  push;
    bsd_pkg::bsd_entry_t   push_data;
    logic                  pop;
    bsd_pkg::bsd_entry_t   pop_data;
    logic                  q_empty;
    logic                  q_full;
    logic                  q_almost_full;
    bsd_pkg::bsd_result_t  result;

    // The parser register holds one entry in flight, so stall one slot early.
    assign byte_stall = q_almost_full;
    assign accept     = byte_valid && !byte_stall;

    bsd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .end_of_file   (end_of_file),
        .push          (push),
        .push_data     (push_data)
    );

    bsd_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push && !q_full),
        .push_data   (push_data),
        .pop         (pop),
        .pop_data    (pop_data),
        .empty       (q_empty),
        .full        (q_full),
        .almost_full (q_almost_full)
    );

    bsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry        (pop_data),
        .empty        (q_empty),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    // Output fields.
    assign kind         = result.kind;
    assign status       = result.status;
    assign pixel_x      = result.pixel_x;
    assign pixel_y      = result.pixel_y;
    assign red          = result.red;
    assign green        = result.green;
    assign blue         = result.blue;
    assign alpha        = result.alpha;
    assign image_width  = result.image_width;
    assign image_height = result.image_height;
    assign last_pixel   = result.last_pixel;
    assign last_in_run  = result.last_in_run;

endmodule

`default_nettype wire

### sv/bsd_checker.sv
// Port-level checker for the bitmap stream decoder, bound to the top level.
// Depends on bsd_pkg and bmp_stream_decoder_top_assert.svh.
`default_nettype none

`include "bmp_stream_decoder_top_assert.svh"

module bsd_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         result_valid,
    input wire logic         result_stall,
    input wire logic [1:0]   kind,
    input wire logic [3:0]   status,
    input wire logic [11:0]  pixel_x,
    input wire logic [12:0]  image_width,
    input wire logic [12:0]  image_height,
    input wire logic         last_pixel,
    input wire logic         last_in_run
);

    // A stalled result keeps its kind, status and pixel_x.
    `BSD_ASSERT_NEXT(a_stall_hold, result_valid && result_stall, result_valid && $stable(kind) && $stable(status) && $stable(pixel_x), "stalled result changed")

    // A pixel carries no status and no image size.
    `BSD_ASSERT_NOW(a_pixel_fields, result_valid && kind == bsd_pkg::KIND_PIXEL, status == bsd_pkg::ST_OK && image_width == 13'd0 && image_height == 13'd0, "pixel result with header fields")

    // An error always closes the run of results from its byte, with a non-OK status and a zero pixel_x.
    `BSD_ASSERT_NOW(a_error_last, result_valid && kind == bsd_pkg::KIND_ERROR, last_in_run && status != bsd_pkg::ST_OK && pixel_x == 12'd0, "error result malformed")

    // The final pixel flag appears on pixels only.
    `BSD_ASSERT_NOW(a_last_pixel_kind, result_valid && last_pixel, kind == bsd_pkg::KIND_PIXEL, "last_pixel on a non-pixel result")

endmodule

bind bmp_stream_decoder_top bsd_checker u_bsd_checker (.*);

`default_nettype wire
